### design/mrq_pkg.sv
// Shared types and codes for the message ring queue.
`default_nettype none

package mrq_pkg;

    // Command codes carried by an input beat.
    typedef enum logic [1:0] {
        CMD_WRITE_BYTE  = 2'd0,
        CMD_WRITE_EMPTY = 2'd1,
        CMD_READ        = 2'd2
    } t_cmd;

    // Status codes carried by a result beat.
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_EMPTY      = 2'd2,
        ST_HEAD_EMPTY = 2'd3
    } t_status;

    // Progress of the message that is being written.
    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_ACCEPT = 2'd1,
        MODE_DROP   = 2'd2
    } t_wr_mode;

    // Payload of one input beat.
    typedef struct packed {
        t_cmd       command;
        logic [7:0] data_in;
        logic       last;
    } t_in_beat;

    // Payload of one result beat.
    typedef struct packed {
        logic [7:0] data_out;
        logic       data_valid;
        logic       msg_done;
        t_status    status;
        logic [7:0] byte_count;
        logic [3:0] queue_level;
    } t_out_beat;

endpackage

`default_nettype wire

### design/mrq_stream_if.sv
// Valid/ready stream channel with a typed payload.
`default_nettype none

interface mrq_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/mrq_ram.sv
// Simple dual-port synchronous RAM, registered read, new data on a same-address collision.
`default_nettype none

module mrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read; a write to the same entry in the same cycle is passed through.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_q <= i_wdata;
            end else begin
                r_q <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

### design/mrq_ctrl.sv
// Queue pointers, write and read progress, and the per-beat update of the queue.
`default_nettype none

module mrq_ctrl #(
    parameter int QUEUE_DEPTH   = 15,
    parameter int MESSAGE_BYTES = 250,
    localparam int SLOT_W = $clog2(QUEUE_DEPTH),
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1),
    localparam int LEN_W  = $clog2(MESSAGE_BYTES + 1),
    localparam int ADDR_W = $clog2(QUEUE_DEPTH * MESSAGE_BYTES)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_fire,
    input  wire mrq_pkg::t_in_beat  i_item,
    input  wire logic [7:0]         i_store_rdata,
    input  wire logic [LEN_W-1:0]   i_len_rdata,
    output logic      [ADDR_W-1:0]  o_store_raddr,
    output logic      [SLOT_W-1:0]  o_len_raddr,
    output logic                    o_store_we,
    output logic      [ADDR_W-1:0]  o_store_waddr,
    output logic      [7:0]         o_store_wdata,
    output logic                    o_len_we,
    output logic      [SLOT_W-1:0]  o_len_waddr,
    output logic      [LEN_W-1:0]   o_len_wdata,
    output mrq_pkg::t_out_beat      o_result
);

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(QUEUE_DEPTH);
    localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(MESSAGE_BYTES);
    localparam logic [ADDR_W-1:0] BASE_STEP = ADDR_W'(MESSAGE_BYTES);

    logic [SLOT_W-1:0]       r_head, n_head;
    logic [ADDR_W-1:0]       r_head_base, n_head_base;
    logic [SLOT_W-1:0]       r_tail, n_tail;
    logic [ADDR_W-1:0]       r_tail_base, n_tail_base;
    logic [CNT_W-1:0]        r_held, n_held;
    logic [LEN_W-1:0]        r_wr_off, n_wr_off;
    mrq_pkg::t_wr_mode       r_wr_mode, n_wr_mode;
    logic                    r_zero_seen, n_zero_seen;
    logic [LEN_W-1:0]        r_zero_len, n_zero_len;
    logic [LEN_W-1:0]        r_rd_off, n_rd_off;

    // Per-beat update: decide the result, the memory writes and the next pointers.
    always_comb begin
        mrq_pkg::t_wr_mode mode;
        logic [LEN_W-1:0]  off;
        logic              zs;
        logic [LEN_W-1:0]  zl;
        logic [LEN_W-1:0]  roff;
        logic              commit;
        logic [LEN_W-1:0]  commit_len;

        mode        = r_wr_mode;
        off         = r_wr_off;
        zs          = r_zero_seen;
        zl          = r_zero_len;
        roff        = r_rd_off;
        commit      = 1'b0;
        commit_len  = '0;

        n_head      = r_head;
        n_head_base = r_head_base;
        n_tail      = r_tail;
        n_tail_base = r_tail_base;
        n_held      = r_held;
        n_rd_off    = r_rd_off;

        o_store_we    = 1'b0;
        o_store_waddr = r_tail_base + ADDR_W'(r_wr_off);
        o_store_wdata = i_item.data_in;
        o_len_we      = 1'b0;
        o_len_waddr   = r_tail;
        o_len_wdata   = '0;

        o_result            = '0;
        o_result.status     = mrq_pkg::ST_OK;

        if (i_fire) begin
            case (i_item.command)
                mrq_pkg::CMD_WRITE_BYTE: begin
                    // The first beat of a message decides whether it is kept or dropped.
                    if (mode == mrq_pkg::MODE_IDLE) begin
                        off  = '0;
                        zs   = 1'b0;
                        zl   = '0;
                        mode = (r_held < CNT_FULL) ? mrq_pkg::MODE_ACCEPT
                                                   : mrq_pkg::MODE_DROP;
                    end
                    if (mode == mrq_pkg::MODE_ACCEPT) begin
                        // Bytes past the slot size are discarded.
                        if (off < LEN_MAX) begin
                            o_store_we    = 1'b1;
                            o_store_waddr = r_tail_base + ADDR_W'(off);
                            if ((i_item.data_in == 8'd0) && !zs) begin
                                zs = 1'b1;
                                zl = off;
                            end
                            off = off + 1'b1;
                        end
                        o_result.byte_count = 8'(off);
                        if (i_item.last) begin
                            commit     = 1'b1;
                            commit_len = zs ? zl : off;
                        end
                    end else begin
                        o_result.status = mrq_pkg::ST_FULL;
                        if (i_item.last) begin
                            mode = mrq_pkg::MODE_IDLE;
                        end
                    end
                end
                mrq_pkg::CMD_WRITE_EMPTY: begin
                    // Ignored while a message is in progress.
                    if (mode == mrq_pkg::MODE_IDLE) begin
                        if (r_held < CNT_FULL) begin
                            commit     = 1'b1;
                            commit_len = '0;
                        end else begin
                            o_result.status = mrq_pkg::ST_FULL;
                        end
                    end
                end
                mrq_pkg::CMD_READ: begin
                    if (r_held == '0) begin
                        o_result.status = mrq_pkg::ST_EMPTY;
                    end else if (i_len_rdata == '0) begin
                        // An empty head message is never popped.
                        o_result.status = mrq_pkg::ST_HEAD_EMPTY;
                    end else begin
                        o_result.data_out   = i_store_rdata;
                        o_result.data_valid = 1'b1;
                        roff                = r_rd_off + 1'b1;
                        o_result.byte_count = 8'(roff);
                        if ((roff >= i_len_rdata) || i_item.last) begin
                            o_result.msg_done = 1'b1;
                            n_held            = r_held - 1'b1;
                            n_rd_off          = '0;
                            if (r_head == SLOT_LAST) begin
                                n_head      = '0;
                                n_head_base = '0;
                            end else begin
                                n_head      = r_head + 1'b1;
                                n_head_base = r_head_base + BASE_STEP;
                            end
                        end else begin
                            n_rd_off = roff;
                        end
                    end
                end
                default: begin
                end
            endcase

            // Commit the message at the tail slot.
            if (commit) begin
                o_len_we          = 1'b1;
                o_len_wdata       = commit_len;
                n_held            = r_held + 1'b1;
                off               = '0;
                zs                = 1'b0;
                zl                = '0;
                mode              = mrq_pkg::MODE_IDLE;
                o_result.msg_done = 1'b1;
                if (r_tail == SLOT_LAST) begin
                    n_tail      = '0;
                    n_tail_base = '0;
                end else begin
                    n_tail      = r_tail + 1'b1;
                    n_tail_base = r_tail_base + BASE_STEP;
                end
            end
        end

        n_wr_mode            = mode;
        n_wr_off             = off;
        n_zero_seen          = zs;
        n_zero_len           = zl;
        o_result.queue_level = 4'(n_held);
    end

    // The next beat reads at the head position that this beat leaves behind.
    assign o_store_raddr = n_head_base + ADDR_W'(n_rd_off);
    assign o_len_raddr   = n_head;

    // Queue state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_head_base <= '0;
            r_tail      <= '0;
            r_tail_base <= '0;
            r_held      <= '0;
            r_wr_off    <= '0;
            r_wr_mode   <= mrq_pkg::MODE_IDLE;
            r_zero_seen <= 1'b0;
            r_zero_len  <= '0;
            r_rd_off    <= '0;
        end else begin
            r_head      <= n_head;
            r_head_base <= n_head_base;
            r_tail      <= n_tail;
            r_tail_base <= n_tail_base;
            r_held      <= n_held;
            r_wr_off    <= n_wr_off;
            r_wr_mode   <= n_wr_mode;
            r_zero_seen <= n_zero_seen;
            r_zero_len  <= n_zero_len;
            r_rd_off    <= n_rd_off;
        end
    end

`ifndef NO_ASSERTIONS
    // The queue never holds more messages than it has slots.
    a_held_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CNT_FULL)
        else $error("message count exceeds queue depth");

    // With nothing held, no read can be part way through a message.
    a_rd_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held == '0) |-> (r_rd_off == '0))
        else $error("read offset nonzero on an empty queue");

    // Write progress exists only while a message is being accepted.
    a_wr_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_mode != mrq_pkg::MODE_ACCEPT) |-> ((r_wr_off == '0) && !r_zero_seen))
        else $error("write progress left over outside an accepted message");

    // The head base address tracks the head slot.
    a_head_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head_base == ADDR_W'(32'(r_head) * MESSAGE_BYTES))
        else $error("head base address out of step with head slot");
`endif

endmodule

`default_nettype wire

### design/message_ring_queue.sv
// Top level of the message ring queue: handshakes, item stage, memories and result register.
`default_nettype none

// A ring of QUEUE_DEPTH message slots of MESSAGE_BYTES bytes each, fed and drained one byte
// per beat. Every input beat yields exactly one result beat. The block takes one beat per
// clock while the result side does not stall. An accepted beat waits in the item stage for
// the registered read of the message store and the length table: the read for a beat is
// issued at its accept edge, with head pointer and read offset taken from the update of the
// beat before it; the update and result are formed as the beat moves from the item stage
// into the output register. A same-entry write and read in one cycle are passed through
// inside the memory. The message store is not cleared at reset and needs no clearing pass:
// only bytes of committed messages are ever read. Reset is synchronous and active low.
module message_ring_queue #(
    parameter int QUEUE_DEPTH   = 15,
    parameter int MESSAGE_BYTES = 250
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    mrq_stream_if.sink    i_in,
    mrq_stream_if.source  o_out
);

    localparam int SLOT_W = $clog2(QUEUE_DEPTH);
    localparam int LEN_W  = $clog2(MESSAGE_BYTES + 1);
    localparam int ADDR_W = $clog2(QUEUE_DEPTH * MESSAGE_BYTES);

    logic                 r_x_valid;
    mrq_pkg::t_in_beat    r_x_item;
    logic                 r_o_valid;
    mrq_pkg::t_out_beat   r_o_beat;

    logic                 out_free;
    logic                 x_fire;
    logic                 in_acc;

    logic [ADDR_W-1:0]    store_raddr;
    logic [SLOT_W-1:0]    len_raddr;
    logic                 store_we;
    logic [ADDR_W-1:0]    store_waddr;
    logic [7:0]           store_wdata;
    logic [7:0]           store_rdata;
    logic                 len_we;
    logic [SLOT_W-1:0]    len_waddr;
    logic [LEN_W-1:0]     len_wdata;
    logic [LEN_W-1:0]     len_rdata;
    mrq_pkg::t_out_beat   result;

    // Handshake: the item stage drains whenever the result register can take its beat.
    assign out_free   = !r_o_valid || o_out.ready;
    assign x_fire     = r_x_valid && out_free;
    assign i_in.ready = !r_x_valid || x_fire;
    assign in_acc     = i_in.valid && i_in.ready;

    // Item stage: holds the beat while its memory reads complete.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_valid <= 1'b0;
        end else if (in_acc) begin
            r_x_valid <= 1'b1;
        end else if (x_fire) begin
            r_x_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x_item <= i_in.data;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (x_fire) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (x_fire) begin
            r_o_beat <= result;
        end
    end

    assign o_out.valid = r_o_valid;
    assign o_out.data  = r_o_beat;

    // Queue control.
    mrq_ctrl #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .MESSAGE_BYTES (MESSAGE_BYTES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (x_fire),
        .i_item        (r_x_item),
        .i_store_rdata (store_rdata),
        .i_len_rdata   (len_rdata),
        .o_store_raddr (store_raddr),
        .o_len_raddr   (len_raddr),
        .o_store_we    (store_we),
        .o_store_waddr (store_waddr),
        .o_store_wdata (store_wdata),
        .o_len_we      (len_we),
        .o_len_waddr   (len_waddr),
        .o_len_wdata   (len_wdata),
        .o_result      (result)
    );

    // Message byte store, one slot of MESSAGE_BYTES per message.
    mrq_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH * MESSAGE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (store_waddr),
        .i_wdata (store_wdata),
        .i_re    (in_acc),
        .i_raddr (store_raddr),
        .o_rdata (store_rdata)
    );

    // Readable length of each committed message.
    mrq_ram #(
        .WIDTH (LEN_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_lengths (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (len_waddr),
        .i_wdata (len_wdata),
        .i_re    (in_acc),
        .i_raddr (len_raddr),
        .o_rdata (len_rdata)
    );

endmodule

`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for the message ring queue: stream drivers, scoreboard and stimulus.
`timescale 1ns / 100ps

// Tracks the queue contents beat by beat and checks every result beat against its prediction.
class ring_queue_scoreboard #(int DEPTH = 15, int MSG_BYTES = 250);
    logic [7:0]          msg_bytes [DEPTH * MSG_BYTES];
    int unsigned         slot_length [DEPTH];
    int unsigned         head;
    int unsigned         tail;
    int unsigned         held;
    int unsigned         wr_offset;
    int unsigned         zero_len;
    int unsigned         rd_offset;
    bit                  zero_seen;
    mrq_pkg::t_wr_mode   wr_mode;
    mrq_pkg::t_out_beat  expected_results [$];
    int unsigned         result_index;
    int unsigned         mismatch_count;

    function new();
        foreach (slot_length[i]) slot_length[i] = 0;
        head           = 0;
        tail           = 0;
        held           = 0;
        wr_offset      = 0;
        zero_len       = 0;
        rd_offset      = 0;
        zero_seen      = 1'b0;
        wr_mode        = mrq_pkg::MODE_IDLE;
        result_index   = 0;
        mismatch_count = 0;
    endfunction

    function int unsigned step_slot(int unsigned slot);
        return (slot + 1 >= DEPTH) ? 0 : slot + 1;
    endfunction

    // The readable length stops at the first zero byte, if there was one.
    function void commit_message();
        slot_length[tail] = zero_seen ? zero_len : wr_offset;
        tail      = step_slot(tail);
        held++;
        wr_offset = 0;
        zero_seen = 1'b0;
        zero_len  = 0;
        wr_mode   = mrq_pkg::MODE_IDLE;
    endfunction

    // Applies one accepted input beat to the queue and stores the result it must produce.
    function void note_beat(mrq_pkg::t_in_beat beat);
        mrq_pkg::t_out_beat res;
        int unsigned        len;
        res = '0;
        res.status = mrq_pkg::ST_OK;
        case (beat.command)
            mrq_pkg::CMD_WRITE_BYTE: begin
                // The first byte of a message decides whether the whole message is kept.
                if (wr_mode == mrq_pkg::MODE_IDLE) begin
                    wr_offset = 0;
                    zero_seen = 1'b0;
                    zero_len  = 0;
                    if (held < DEPTH) wr_mode = mrq_pkg::MODE_ACCEPT;
                    else wr_mode = mrq_pkg::MODE_DROP;
                end
                if (wr_mode == mrq_pkg::MODE_ACCEPT) begin
                    if (wr_offset < MSG_BYTES) begin
                        msg_bytes[tail * MSG_BYTES + wr_offset] = beat.data_in;
                        if (beat.data_in == 8'd0 && !zero_seen) begin
                            zero_seen = 1'b1;
                            zero_len  = wr_offset;
                        end
                        wr_offset++;
                    end
                    res.byte_count = 8'(wr_offset);
                    if (beat.last) begin
                        commit_message();
                        res.msg_done = 1'b1;
                    end
                end else begin
                    res.status = mrq_pkg::ST_FULL;
                    if (beat.last) wr_mode = mrq_pkg::MODE_IDLE;
                end
            end
            mrq_pkg::CMD_WRITE_EMPTY: begin
                // Ignored while a message is open.
                if (wr_mode == mrq_pkg::MODE_IDLE) begin
                    if (held < DEPTH) begin
                        wr_offset = 0;
                        zero_seen = 1'b0;
                        commit_message();
                        res.msg_done = 1'b1;
                    end else begin
                        res.status = mrq_pkg::ST_FULL;
                    end
                end
            end
            mrq_pkg::CMD_READ: begin
                if (held == 0) begin
                    res.status = mrq_pkg::ST_EMPTY;
                end else begin
                    len = slot_length[head];
                    if (len == 0) begin
                        res.status = mrq_pkg::ST_HEAD_EMPTY;
                    end else begin
                        res.data_out   = msg_bytes[head * MSG_BYTES + rd_offset];
                        res.data_valid = 1'b1;
                        rd_offset++;
                        res.byte_count = 8'(rd_offset);
                        if (rd_offset >= len || beat.last) begin
                            held--;
                            head         = step_slot(head);
                            rd_offset    = 0;
                            res.msg_done = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        res.queue_level = 4'(held);
        expected_results.push_back(res);
    endfunction

    task flag_mismatch(string what);
        $display("ERROR: result beat %0d: %s", result_index, what);
        mismatch_count++;
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want) flag_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // Compares an accepted result beat with the oldest prediction.
    task check_result(mrq_pkg::t_out_beat got);
        mrq_pkg::t_out_beat want;
        if (expected_results.size() == 0) begin
            flag_mismatch($sformatf("unexpected beat %h", got));
        end else begin
            want = expected_results.pop_front();
            compare_field("data_out", got.data_out, want.data_out);
            compare_field("data_valid", got.data_valid, want.data_valid);
            compare_field("msg_done", got.msg_done, want.msg_done);
            compare_field("status", got.status, want.status);
            compare_field("byte_count", got.byte_count, want.byte_count);
            compare_field("queue_level", got.queue_level, want.queue_level);
        end
        result_index++;
    endtask
endclass

module testbench;

    localparam int QDEPTH       = 15;
    localparam int MSG_BYTES    = 250;
    localparam int RANDOM_BEATS = 1600;
    localparam int CYCLE_LIMIT  = 800_000;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_LONG_MSG = 3;

    // Command code with no meaning; the block must ignore it.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    mrq_stream_if #(.T(mrq_pkg::t_in_beat))  in_beats ();
    mrq_stream_if #(.T(mrq_pkg::t_out_beat)) out_beats ();

    message_ring_queue #(
        .QUEUE_DEPTH   (QDEPTH),
        .MESSAGE_BYTES (MSG_BYTES)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_beats),
        .o_out   (out_beats)
    );

    ring_queue_scoreboard #(QDEPTH, MSG_BYTES) sb;

    int unsigned cycle_count    = 0;
    int unsigned beats_sent     = 0;
    int unsigned counted_beats  = 0;
    int unsigned results_seen   = 0;
    int unsigned send_gap_max   = 0;
    int unsigned recv_gap_max   = 0;
    int unsigned long_msg_count = 0;

    always #1 i_clk = ~i_clk;

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL message_ring_queue");
            $finish;
        end
    end

    // Presents one beat after a random gap and returns at the falling edge after acceptance.
    task automatic send_beat(mrq_pkg::t_cmd cmd, logic [7:0] data, logic last);
        int unsigned gap;
        if (beats_sent % 50 == 0) begin
            case ($urandom_range(0, 2))
                0:       send_gap_max = 0;
                1:       send_gap_max = 3;
                default: send_gap_max = 18;
            endcase
        end
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            in_beats.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_beats.valid = 1'b1;
        in_beats.data  = '{command: cmd, data_in: data, last: last};
        do @(posedge i_clk); while (!in_beats.ready);
        sb.note_beat(in_beats.data);
        beats_sent++;
        if (cmd == mrq_pkg::CMD_WRITE_BYTE || cmd == mrq_pkg::CMD_READ) counted_beats++;
        @(negedge i_clk);
    endtask

    // Streams one message; only the first byte is kept clear of zero unless asked.
    task automatic write_message(int unsigned n_bytes, bit zero_lead);
        logic [7:0] b;
        for (int unsigned i = 0; i < n_bytes; i++) begin
            if (i == 0) b = zero_lead ? 8'd0 : 8'($urandom_range(1, 255));
            else if ($urandom_range(0, 7) == 0) b = 8'd0;
            else b = 8'($urandom);
            send_beat(mrq_pkg::CMD_WRITE_BYTE, b, i == n_bytes - 1);
            if (i != n_bytes - 1 && $urandom_range(0, 11) == 0) send_noise(1'b1);
        end
    endtask

    task automatic read_burst(int unsigned n_reads, bit early_last);
        for (int unsigned i = 0; i < n_reads; i++)
            send_beat(mrq_pkg::CMD_READ, 8'($urandom), early_last && $urandom_range(0, 4) == 0);
    endtask

    // Beats that leave the write state alone. An empty message is only offered inside an
    // open message or to a full queue, so no empty message reaches the head early.
    task automatic send_noise(bit mid_message);
        case ($urandom_range(0, 2))
            0: send_beat(mrq_pkg::t_cmd'(CMD_UNUSED), 8'($urandom), 1'($urandom));
            1: begin
                if (mid_message || sb.held == QDEPTH)
                    send_beat(mrq_pkg::CMD_WRITE_EMPTY, 8'($urandom), 1'($urandom));
                else
                    send_beat(mrq_pkg::CMD_READ, 8'($urandom), 1'($urandom));
            end
            default: send_beat(mrq_pkg::CMD_READ, 8'($urandom), 1'($urandom));
        endcase
    endtask

    function automatic int unsigned pick_length();
        if (long_msg_count < MAX_LONG_MSG && $urandom_range(0, 59) == 0) begin
            long_msg_count++;
            return $urandom_range(MSG_BYTES - 3, MSG_BYTES + 8);
        end
        return $urandom_range(1, 10);
    endfunction

    // Result side: stalls at random, then checks each accepted beat.
    initial begin
        int unsigned gap;
        out_beats.ready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (results_seen % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0:       recv_gap_max = 0;
                    1:       recv_gap_max = 4;
                    default: recv_gap_max = 18;
                endcase
            end
            gap = $urandom_range(0, recv_gap_max);
            if (gap > 0) begin
                out_beats.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_beats.ready = 1'b1;
            do @(posedge i_clk); while (!out_beats.valid);
            sb.check_result(out_beats.data);
            results_seen++;
            @(negedge i_clk);
        end
    end

    // Stimulus: directed opening, random traffic, then the empty-head and full-queue ending.
    initial begin
        int unsigned target;
        int unsigned action;
        int unsigned write_pct;
        int unsigned roll;
        in_beats.valid = 1'b0;
        in_beats.data  = '0;
        sb = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty queue, unused command, and a message with ignored beats inside it.
        send_beat(mrq_pkg::CMD_READ, 8'hFF, 1'b1);
        send_beat(mrq_pkg::t_cmd'(CMD_UNUSED), 8'hAA, 1'b1);
        send_beat(mrq_pkg::CMD_WRITE_BYTE, 8'hFF, 1'b0);
        send_beat(mrq_pkg::CMD_WRITE_EMPTY, 8'h00, 1'b1);
        send_beat(mrq_pkg::t_cmd'(CMD_UNUSED), 8'h55, 1'b0);
        send_beat(mrq_pkg::CMD_WRITE_BYTE, 8'h00, 1'b0);
        send_beat(mrq_pkg::CMD_WRITE_BYTE, 8'h80, 1'b1);
        // A zero byte cut that message to one byte.
        send_beat(mrq_pkg::CMD_READ, 8'h00, 1'b0);
        // The caller's last pops a message before its end.
        send_beat(mrq_pkg::CMD_WRITE_BYTE, 8'h01, 1'b0);
        send_beat(mrq_pkg::CMD_WRITE_BYTE, 8'h02, 1'b0);
        send_beat(mrq_pkg::CMD_WRITE_BYTE, 8'h03, 1'b0);
        send_beat(mrq_pkg::CMD_WRITE_BYTE, 8'h7F, 1'b1);
        send_beat(mrq_pkg::CMD_READ, 8'h00, 1'b0);
        send_beat(mrq_pkg::CMD_READ, 8'h00, 1'b1);
        send_beat(mrq_pkg::CMD_READ, 8'h00, 1'b0);
        // Two messages back to back, read across the boundary.
        send_beat(mrq_pkg::CMD_WRITE_BYTE, 8'h55, 1'b1);
        send_beat(mrq_pkg::CMD_WRITE_BYTE, 8'hAA, 1'b0);
        send_beat(mrq_pkg::CMD_WRITE_BYTE, 8'h01, 1'b1);
        read_burst(4, 1'b0);

        // Random traffic in episodes that lean toward filling or toward draining the queue.
        target    = counted_beats + RANDOM_BEATS;
        action    = 0;
        write_pct = 50;
        while (counted_beats < target) begin
            if (action % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0:       write_pct = 75;
                    1:       write_pct = 50;
                    default: write_pct = 25;
                endcase
            end
            action++;
            roll = $urandom_range(0, 99);
            if (roll < write_pct) begin
                write_message(pick_length(), 1'b0);
            end else if (roll < 92) begin
                if ($urandom_range(0, 29) == 0) read_burst(MSG_BYTES + 2, 1'b0);
                else read_burst($urandom_range(1, 12), 1'b1);
            end else begin
                send_noise(1'b0);
            end
        end

        // Drain, then park empty messages at the head: reads report an empty head from here on.
        while (sb.held != 0) send_beat(mrq_pkg::CMD_READ, 8'($urandom), 1'b1);
        write_message(3, 1'b1);
        send_beat(mrq_pkg::CMD_WRITE_EMPTY, 8'($urandom), 1'b0);
        send_beat(mrq_pkg::CMD_READ, 8'($urandom), 1'b0);
        send_beat(mrq_pkg::CMD_READ, 8'($urandom), 1'b1);
        while (sb.held < QDEPTH) write_message($urandom_range(1, 4), 1'b0);
        // A full queue drops whole messages and refuses empty ones.
        write_message(3, 1'b0);
        send_beat(mrq_pkg::CMD_WRITE_EMPTY, 8'($urandom), 1'b1);
        send_beat(mrq_pkg::CMD_READ, 8'($urandom), 1'b0);
        send_beat(mrq_pkg::CMD_READ, 8'($urandom), 1'b1);
        in_beats.valid = 1'b0;

        // Let the outstanding results come back, then watch for strays.
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.expected_results.size() == 0) begin
            $display("PASS message_ring_queue");
        end else begin
            $display("FAIL message_ring_queue");
        end
        $finish;
    end

endmodule
